[hw/rtl/gtl_pkg.sv]
package gtl_pkg;

  // Screen geometry in pixels
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  // Field widths
  localparam int SIZE_W = 5;
  localparam int ADDR_W = 24;
  localparam int SQ_W   = 2 * SIZE_W;
  localparam int CNT_W  = $clog2(SQ_W + 1);

  // GB2312 table geometry
  localparam logic [7:0] GB_FIRST   = 8'hA1;
  localparam int         GB_PER_ROW = 94;

  // Text codes
  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_END = 8'd0;

  // Input operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Glyph kinds
  localparam logic KIND_ASCII = 1'b0;
  localparam logic KIND_GB    = 1'b1;

  // Configuration register indexes
  localparam logic CFG_FONT_SIZE = 1'b0;
  localparam logic CFG_FONT_BASE = 1'b1;

  localparam logic [SIZE_W-1:0] FONT_SIZE_RST = SIZE_W'(16);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SEND
  } state_t;

  // Request to the font address unit
  typedef struct packed {
    logic       start;
    logic [7:0] hi;
    logic [7:0] lo;
  } mul_req_t;

  // Status back from the font address unit
  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] addr;
  } mul_rsp_t;

endpackage

[hw/rtl/gtl_addr_mul.sv]
module gtl_addr_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gtl_pkg::mul_req_t             req,
  input  logic [gtl_pkg::SIZE_W-1:0]    font_size,
  input  logic [gtl_pkg::ADDR_W-1:0]    font_base,
  output gtl_pkg::mul_rsp_t             rsp
);
  import gtl_pkg::*;

  logic                run_r, run_nxt;
  logic                fin_r, fin_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   acc_r, acc_nxt;
  logic [ADDR_W-1:0]   mc_r, mc_nxt;
  logic [SQ_W-1:0]     sq_r, sq_nxt;
  logic                neg_r, neg_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;

  logic signed [8:0]   hi_d;
  logic signed [8:0]   lo_d;
  logic signed [15:0]  idx;
  logic [14:0]         mag;
  logic [ADDR_W-1:0]   off;

  // Glyph index from the byte pair, then its sign and magnitude
  always_comb begin
    hi_d = $signed({1'b0, req.hi}) - $signed({1'b0, GB_FIRST});
    lo_d = $signed({1'b0, req.lo}) - $signed({1'b0, GB_FIRST});
    idx  = 16'(hi_d * 16'sd94) + 16'(lo_d);
    mag  = idx[15] ? 15'(-idx) : idx[14:0];
  end

  // Shift-and-add over the bits of size squared, then scale and add base
  always_comb begin
    run_nxt  = run_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    sq_nxt   = sq_r;
    neg_nxt  = neg_r;
    addr_nxt = addr_r;
    off      = {3'b000, acc_r[ADDR_W-1:3]};
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(SQ_W);
      acc_nxt = '0;
      mc_nxt  = ADDR_W'(mag);
      sq_nxt  = SQ_W'(font_size * font_size);
      neg_nxt = idx[15];
    end else if (run_r) begin
      if (sq_r[0]) begin
        acc_nxt = acc_r + mc_r;
      end
      mc_nxt  = {mc_r[ADDR_W-2:0], 1'b0};
      sq_nxt  = {1'b0, sq_r[SQ_W-1:1]};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt = 1'b0;
        fin_nxt = 1'b1;
      end
    end
    // Truncating divide by 8 on the magnitude, negate through carry in
    if (fin_r) begin
      addr_nxt = font_base + (neg_r ? ~off : off) + ADDR_W'(neg_r);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    mc_r   <= mc_nxt;
    sq_r   <= sq_nxt;
    neg_r  <= neg_nxt;
    addr_r <= addr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.addr = addr_r;

endmodule

[hw/rtl/gb2312_text_layout.sv]
// Text cursor for a small screen: a start item (op 0) sets the line start
// column and row, then text bytes (op 1) each give at most one glyph item.
// ASCII bytes and the cursor update finish in the accept cycle; their item
// is staged there and goes to the output register from the send state once
// that register is free. A GB2312 pair gives its item after the second byte,
// once the font address unit has run: a shift-and-add multiplier that takes
// one bit of size squared per cycle, then a step for the divide by 8 and base
// add. Bytes without a result (high byte, carriage return, zero, start) leave
// the block idle and ready for the next item. A new item is taken while the
// previous result still waits in the output register.
module gb2312_text_layout (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [gtl_pkg::ADDR_W-1:0]  cfg_wdata,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [6:0]                  in_start_column,
  input  logic [5:0]                  in_start_row,
  input  logic [7:0]                  in_text_byte,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_glyph_kind,
  output logic [6:0]                  out_glyph_column,
  output logic [7:0]                  out_glyph_row,
  output logic [15:0]                 out_char_code,
  output logic [gtl_pkg::ADDR_W-1:0]  out_font_address
);
  import gtl_pkg::*;

  logic [SIZE_W-1:0]  size_r;
  logic [ADDR_W-1:0]  base_r;

  state_t             state_r, state_nxt;
  logic [7:0]         col_r, col_nxt;
  logic [7:0]         row_r, row_nxt;
  logic [6:0]         ls_r, ls_nxt;
  logic [7:0]         pend_r, pend_nxt;
  logic               pend_vld_r, pend_vld_nxt;

  logic               st_kind_r, st_kind_nxt;
  logic [6:0]         st_col_r, st_col_nxt;
  logic [7:0]         st_row_r, st_row_nxt;
  logic [15:0]        st_code_r, st_code_nxt;

  logic               out_vld_r, out_vld_nxt;
  logic               load_out;
  logic               o_kind_r;
  logic [6:0]         o_col_r;
  logic [7:0]         o_row_r;
  logic [15:0]        o_code_r;
  logic [ADDR_W-1:0]  o_addr_r;

  logic [SIZE_W-1:0]  adv;
  logic               wrap;
  logic [7:0]         row_step;
  logic [7:0]         col_w;
  logic [7:0]         row_w;
  logic [7:0]         row_w_step;

  mul_req_t           mreq;
  mul_rsp_t           mrsp;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= FONT_SIZE_RST;
      base_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FONT_SIZE: size_r <= cfg_wdata[SIZE_W-1:0];
        CFG_FONT_BASE: base_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Wrap check ahead of a glyph
  always_comb begin
    adv        = pend_vld_r ? size_r : {1'b0, size_r[SIZE_W-1:1]};
    wrap       = ({1'b0, col_r} + 9'(adv)) > 9'(SCREEN_WIDTH);
    row_step   = row_r + 8'(size_r);
    col_w      = wrap ? {1'b0, ls_r} : col_r;
    row_w      = row_r;
    if (wrap) begin
      row_w = ({1'b0, row_step} >= 9'(SCREEN_HEIGHT)) ? 8'd0 : row_step;
    end
    row_w_step = row_w + 8'(size_r);
  end

  // Item decode, cursor update and result handoff
  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    ls_nxt       = ls_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    st_kind_nxt  = st_kind_r;
    st_col_nxt   = st_col_r;
    st_row_nxt   = st_row_r;
    st_code_nxt  = st_code_r;
    in_ready     = 1'b0;
    load_out     = 1'b0;
    mreq.start   = 1'b0;
    mreq.hi      = pend_r;
    mreq.lo      = in_text_byte;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_START) begin
            ls_nxt       = in_start_column;
            col_nxt      = {1'b0, in_start_column};
            row_nxt      = {2'b00, in_start_row};
            pend_vld_nxt = 1'b0;
          end else if (in_text_byte == CHAR_END) begin
            pend_vld_nxt = 1'b0;
          end else if (pend_vld_r) begin
            pend_vld_nxt = 1'b0;
            st_kind_nxt  = KIND_GB;
            st_col_nxt   = col_w[6:0];
            st_row_nxt   = row_w;
            st_code_nxt  = {pend_r, in_text_byte};
            col_nxt      = col_w + 8'(size_r);
            row_nxt      = row_w;
            mreq.start   = 1'b1;
            state_nxt    = ST_MUL;
          end else if (in_text_byte[7]) begin
            pend_nxt     = in_text_byte;
            pend_vld_nxt = 1'b1;
          end else if (in_text_byte == CHAR_CR) begin
            col_nxt = {1'b0, ls_r};
            row_nxt = row_w_step;
          end else begin
            st_kind_nxt = KIND_ASCII;
            st_col_nxt  = col_w[6:0];
            st_row_nxt  = row_w;
            st_code_nxt = {8'd0, in_text_byte};
            col_nxt     = col_w + 8'(size_r[SIZE_W-1:1]);
            row_nxt     = row_w;
            state_nxt   = ST_SEND;
          end
        end
      end
      ST_MUL: begin
        if (mrsp.done) begin
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (!out_vld_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register valid: set on load, drop when taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      col_r      <= '0;
      row_r      <= '0;
      ls_r       <= '0;
      pend_r     <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      ls_r       <= ls_nxt;
      pend_r     <= pend_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Hold staged fields and the output payload
  always_ff @(posedge clk) begin
    st_kind_r <= st_kind_nxt;
    st_col_r  <= st_col_nxt;
    st_row_r  <= st_row_nxt;
    st_code_r <= st_code_nxt;
    if (load_out) begin
      o_kind_r <= st_kind_r;
      o_col_r  <= st_col_r;
      o_row_r  <= st_row_r;
      o_code_r <= st_code_r;
      o_addr_r <= (st_kind_r == KIND_GB) ? mrsp.addr : '0;
    end
  end

  gtl_addr_mul u_addr_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mreq),
    .font_size (size_r),
    .font_base (base_r),
    .rsp       (mrsp)
  );

  assign out_valid        = out_vld_r;
  assign out_glyph_kind   = o_kind_r;
  assign out_glyph_column = o_col_r;
  assign out_glyph_row    = o_row_r;
  assign out_char_code    = o_code_r;
  assign out_font_address = o_addr_r;

endmodule

[verif/tb_gb2312_text_layout.sv]
`timescale 1ns / 1ps

module tb_gb2312_text_layout;
  import gtl_pkg::*;

  localparam logic [7:0] GB_HIGH_MIN  = 8'd128;
  localparam int         PHASE_ITEMS  = 250;
  localparam int         PHASES       = 7;
  localparam int         SETTLE_CYC   = 20;
  localparam int         DRAIN_LIMIT  = 2000;

  typedef struct packed {
    logic       op;
    logic [6:0] col;
    logic [5:0] row;
    logic [7:0] text;
  } text_item_t;

  typedef struct packed {
    logic              kind;
    logic [6:0]        col;
    logic [7:0]        row;
    logic [15:0]       code;
    logic [ADDR_W-1:0] addr;
  } placement_t;

  typedef struct packed {
    text_item_t it;
    logic       typed;
    placement_t res;
  } script_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_index;
  logic [ADDR_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic              in_op;
  logic [6:0]        in_start_column;
  logic [5:0]        in_start_row;
  logic [7:0]        in_text_byte;
  logic              out_valid;
  logic              out_ready;
  logic              out_glyph_kind;
  logic [6:0]        out_glyph_column;
  logic [7:0]        out_glyph_row;
  logic [15:0]       out_char_code;
  logic [ADDR_W-1:0] out_font_address;

  gb2312_text_layout DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_start_column  (in_start_column),
    .in_start_row     (in_start_row),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_glyph_kind   (out_glyph_kind),
    .out_glyph_column (out_glyph_column),
    .out_glyph_row    (out_glyph_row),
    .out_char_code    (out_char_code),
    .out_font_address (out_font_address)
  );

  // Cursor model and its copy of the registers
  logic [7:0]        cur_col;
  logic [7:0]        cur_row;
  logic [6:0]        line_col;
  logic [7:0]        pend_hi;
  logic              pend_ok;
  logic [SIZE_W-1:0] font_size_q;
  logic [ADDR_W-1:0] font_base_q;

  placement_t  placement_q[$];
  script_row_t script[$];

  bit src_gaps;
  bit sink_stalls;
  int errors;
  int items_sent;
  int ascii_seen;
  int gb_seen;
  int settings_run;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop for a hung handshake
  initial begin
    #5_000_000;
    $display("Timeout: %0d placements still expected", placement_q.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic void new_line();
    cur_col = {1'b0, line_col};
    cur_row = cur_row + 8'(font_size_q);
  endfunction

  // Wrap to the next line when a glyph of this width would cross the edge
  function automatic void wrap_for(input int adv);
    if (int'(cur_col) > SCREEN_WIDTH - adv) begin
      new_line();
      if (int'(cur_row) >= SCREEN_HEIGHT) cur_row = 8'd0;
    end
  endfunction

  function automatic logic [ADDR_W-1:0] flash_addr(input logic [7:0] hi, input logic [7:0] lo);
    int idx;
    int prod;
    int off;
    idx  = (int'(hi) - int'(GB_FIRST)) * GB_PER_ROW + int'(lo) - int'(GB_FIRST);
    prod = idx * int'(font_size_q) * int'(font_size_q);
    off  = prod / 8;
    return font_base_q + off[ADDR_W-1:0];
  endfunction

  // Advance the cursor model by one item; return 1 when a glyph is placed
  function automatic bit place_glyph(input text_item_t it, output placement_t p);
    p = '0;
    if (it.op == OP_START) begin
      line_col = it.col;
      cur_col  = {1'b0, it.col};
      cur_row  = {2'b00, it.row};
      pend_ok  = 1'b0;
      return 1'b0;
    end
    if (it.text == CHAR_END) begin
      pend_ok = 1'b0;
      return 1'b0;
    end
    if (pend_ok) begin
      pend_ok = 1'b0;
      wrap_for(int'(font_size_q));
      p.kind  = KIND_GB;
      p.col   = cur_col[6:0];
      p.row   = cur_row;
      p.code  = {pend_hi, it.text};
      p.addr  = flash_addr(pend_hi, it.text);
      cur_col = cur_col + 8'(font_size_q);
      return 1'b1;
    end
    if (it.text >= GB_HIGH_MIN) begin
      pend_hi = it.text;
      pend_ok = 1'b1;
      return 1'b0;
    end
    wrap_for(int'(font_size_q) / 2);
    if (it.text == CHAR_CR) begin
      new_line();
      return 1'b0;
    end
    p.kind  = KIND_ASCII;
    p.col   = cur_col[6:0];
    p.row   = cur_row;
    p.code  = {8'd0, it.text};
    p.addr  = '0;
    cur_col = cur_col + 8'(font_size_q >> 1);
    return 1'b1;
  endfunction

  function automatic text_item_t byte_item(input logic [7:0] b);
    text_item_t it;
    it.op   = OP_BYTE;
    it.col  = 7'($urandom_range(0, 127));
    it.row  = 6'($urandom_range(0, 63));
    it.text = b;
    return it;
  endfunction

  function automatic text_item_t start_item(input logic [6:0] c, input logic [5:0] r);
    text_item_t it;
    it.op   = OP_START;
    it.col  = c;
    it.row  = r;
    it.text = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic void add_row(input text_item_t it);
    script_row_t s;
    s.it    = it;
    s.typed = 1'b0;
    s.res   = '0;
    script.push_back(s);
  endfunction

  function automatic void add_glyph(input logic [7:0] b, input logic kind, input logic [6:0] c,
                                    input logic [7:0] r, input logic [15:0] code,
                                    input logic [ADDR_W-1:0] addr);
    script_row_t s;
    s.it    = byte_item(b);
    s.typed = 1'b1;
    s.res   = '{kind, c, r, code, addr};
    script.push_back(s);
  endfunction

  // Present one item, hold it until accepted, then queue its expected glyph
  task automatic send_item(input text_item_t it, input bit typed, input placement_t typed_p);
    placement_t p;
    bit         has;
    @(negedge clk);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_op           = it.op;
    in_start_column = it.col;
    in_start_row    = it.row;
    in_text_byte    = it.text;
    in_valid        = 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    has = place_glyph(it, p);
    if (has) placement_q.push_back(typed ? typed_p : p);
    items_sent++;
  endtask

  // Drop valid and let the block finish before touching a register
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_FONT_SIZE) font_size_q = val[SIZE_W-1:0];
    else font_base_q = val;
  endtask

  // Mostly well-formed strings with random content, some raw noise
  task automatic run_phase(input int n);
    int         sent;
    int         k;
    text_item_t it;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        send_item(start_item(7'($urandom_range(0, 127)), 6'($urandom_range(0, 63))), 0, '0);
        sent++;
        repeat ($urandom_range(1, 20)) begin
          k = $urandom_range(0, 99);
          if (k < 55) begin
            send_item(byte_item(8'($urandom_range(32, 126))), 0, '0);
          end else if (k < 62) begin
            send_item(byte_item(8'($urandom_range(1, 127))), 0, '0);
          end else if (k < 70) begin
            send_item(byte_item(CHAR_CR), 0, '0);
          end else begin
            send_item(byte_item(8'($urandom_range(8'hA1, 8'hF7))), 0, '0);
            send_item(byte_item(8'($urandom_range(8'hA1, 8'hFE))), 0, '0);
            sent++;
          end
          sent++;
        end
        if ($urandom_range(0, 1) == 1) begin
          send_item(byte_item(CHAR_END), 0, '0);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          it.op   = 1'($urandom_range(0, 1));
          it.col  = 7'($urandom_range(0, 127));
          it.row  = 6'($urandom_range(0, 63));
          it.text = 8'($urandom_range(0, 255));
          send_item(it, 0, '0);
          sent++;
        end
      end
    end
  endtask

  // Result side: stall in random bursts
  always begin
    @(negedge clk);
    if (sink_stalls && $urandom_range(0, 4) == 0) begin
      out_ready = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    out_ready = 1'b1;
  end

  // Compare each accepted glyph with the oldest expectation
  placement_t got_p;
  placement_t want_p;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_p = '{out_glyph_kind, out_glyph_column, out_glyph_row, out_char_code,
                out_font_address};
      if (placement_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR %0t: unexpected glyph kind=%0d col=%0d row=%0d code=%h addr=%h",
                   $time, got_p.kind, got_p.col, got_p.row, got_p.code, got_p.addr);
      end else begin
        want_p = placement_q.pop_front();
        if (got_p !== want_p) begin
          errors++;
          if (errors <= 10) begin
            $display("ERROR %0t: glyph mismatch", $time);
            $display("  exp kind=%0d col=%0d row=%0d code=%h addr=%h",
                     want_p.kind, want_p.col, want_p.row, want_p.code, want_p.addr);
            $display("  got kind=%0d col=%0d row=%0d code=%h addr=%h",
                     got_p.kind, got_p.col, got_p.row, got_p.code, got_p.addr);
          end
        end
        if (want_p.kind == KIND_GB) gb_seen++;
        else ascii_seen++;
      end
    end
  end

  initial begin
    int                k;
    int                waited;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] val;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_FONT_SIZE;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_op           = OP_START;
    in_start_column = '0;
    in_start_row    = '0;
    in_text_byte    = '0;
    out_ready       = 1'b0;
    src_gaps        = 1'b1;
    sink_stalls     = 1'b1;

    cur_col     = '0;
    cur_row     = '0;
    line_col    = '0;
    pend_hi     = '0;
    pend_ok     = 1'b0;
    font_size_q = FONT_SIZE_RST;
    font_base_q = '0;

    // Directed script at reset settings: size 16, base 0
    add_row(start_item(7'd0, 6'd0));
    add_glyph(8'h41, KIND_ASCII, 7'd0, 8'd0, 16'h0041, '0);
    add_row(byte_item(8'hA1));
    add_glyph(8'hA1, KIND_GB, 7'd8, 8'd0, 16'hA1A1, '0);
    add_row(byte_item(CHAR_CR));
    add_glyph(8'h7F, KIND_ASCII, 7'd0, 8'd16, 16'h007F, '0);
    add_row(byte_item(8'hFF));
    add_glyph(8'hFF, KIND_GB, 7'd8, 8'd16, 16'hFFFF, 24'h045C40);
    // low byte below 128 gives a negative table index
    add_row(byte_item(8'h80));
    add_row(byte_item(8'h01));
    // string end drops a pending high byte
    add_row(byte_item(8'hB0));
    add_row(byte_item(CHAR_END));
    add_row(byte_item(8'h01));
    // carriage return taken as a low byte
    add_row(byte_item(8'hF7));
    add_row(byte_item(CHAR_CR));
    // start drops a pending high byte; wrap past the bottom returns to row 0
    add_row(byte_item(8'hC0));
    add_row(start_item(7'd127, 6'd63));
    add_glyph(8'h5A, KIND_ASCII, 7'd127, 8'd0, 16'h005A, '0);
    add_row(byte_item(8'h5A));
    // carriage returns run below the screen without returning to row 0
    add_row(start_item(7'd100, 6'd40));
    repeat (4) add_row(byte_item(CHAR_CR));
    add_row(byte_item(8'h20));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    settings_run = 1;
    for (k = 0; k < script.size(); k++) send_item(script[k].it, script[k].typed, script[k].res);

    // Random phases, each under its own font setting
    for (k = 1; k <= PHASES; k++) begin
      case (k)
        1: begin sz = 5'd8;  base = ADDR_W'($urandom); end
        2: begin sz = 5'd12; base = '1; end
        3: begin sz = 5'd24; base = ADDR_W'($urandom); end
        4: begin sz = 5'd31; base = '0; end
        5: begin sz = 5'd0;  base = ADDR_W'($urandom); end
        6: begin sz = 5'($urandom_range(1, 31)); base = ADDR_W'($urandom); end
        default: begin sz = 5'd16; base = ADDR_W'($urandom); end
      endcase
      settle();
      val = ADDR_W'($urandom);
      val[SIZE_W-1:0] = sz;
      write_reg(CFG_FONT_SIZE, val);
      write_reg(CFG_FONT_BASE, base);
      settings_run++;
      src_gaps    = (k != 4) && (k != PHASES);
      sink_stalls = (k != 3) && (k != PHASES);
      run_phase(PHASE_ITEMS);
    end

    // Drain outstanding glyphs, then watch for strays
    @(negedge clk);
    in_valid = 1'b0;
    waited = 0;
    while (placement_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (placement_q.size() != 0) begin
      errors += placement_q.size();
      $display("ERROR: %0d expected glyphs never arrived", placement_q.size());
    end

    $display("Sent %0d text items under %0d font settings (sizes 0 to 31, base 0 to max)",
             items_sent, settings_run);
    $display("Checked %0d ASCII and %0d GB2312 placements, %0d mismatches",
             ascii_seen, gb_seen, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
